>>> src/oldq_pkg.sv
`timescale 1ns / 1ps

package oldq_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_PUSH   = 3'd0,
        REQ_POP    = 3'd1,
        REQ_SHIFT  = 3'd2,
        REQ_GET    = 3'd3,
        REQ_DELETE = 3'd4,
        REQ_REMOVE = 3'd5,
        REQ_COUNT  = 3'd6,
        REQ_NONE   = 3'd7
    } req_kind_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  position;
        logic [31:0] item_value;
    } req_beat_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] read_value;
        logic [4:0]  entry_count;
    } rsp_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_RESP = 2'd2
    } ctrl_state_t;

    // command from controller to datapath
    typedef struct packed {
        logic load;   // capture request
        logic exec;   // perform operation, latch result
    } dp_cmd_t;

endpackage

>>> src/oldq_datapath.sv
`timescale 1ns / 1ps

module oldq_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  oldq_pkg::dp_cmd_t   cmd,
    input  oldq_pkg::req_beat_t req_in,
    output oldq_pkg::rsp_beat_t rsp_out
);

    localparam int D  = oldq_pkg::DEPTH;
    localparam int VW = oldq_pkg::VALUE_WIDTH;
    localparam int IW = oldq_pkg::IDX_W;
    localparam int CW = oldq_pkg::CNT_W;

    logic [VW-1:0] entries_reg [D];
    logic [VW-1:0] entries_next [D];
    logic [CW-1:0] count_reg, count_next;
    oldq_pkg::req_beat_t req_reg;
    oldq_pkg::rsp_beat_t rsp_reg, rsp_next;

    logic [VW-1:0] val;
    logic [D-1:0]  match;
    logic [D-1:0]  first_hit;
    logic [D-1:0]  below_cnt;
    logic [D-1:0]  del_mask;   // cells at or above the removed slot take their upper neighbour
    logic          in_range;
    logic          del_en;
    logic          ok;
    logic [VW-1:0] rv;
    logic [IW-1:0] pos_idx;
    logic [IW-1:0] top_idx;

    assign val     = VW'(req_reg.item_value);
    assign pos_idx = req_reg.position[IW-1:0];
    assign top_idx = IW'(count_reg - CW'(1));
    assign in_range = (32'(req_reg.position) < 32'(count_reg))
                      && (32'(req_reg.position) < 32'(D));

    // per-cell compare and first-hit priority
    always_comb begin
        for (int i = 0; i < D; i++) begin
            below_cnt[i] = (CW'(i) < count_reg);
            match[i]     = below_cnt[i] && (entries_reg[i] == val);
        end
        first_hit = match & (~match + D'(1));
    end

    // operation decode, shift cells
    always_comb begin
        ok         = 1'b0;
        rv         = '0;
        del_en     = 1'b0;
        del_mask   = '0;
        count_next = count_reg;
        for (int i = 0; i < D; i++) entries_next[i] = entries_reg[i];
        case (oldq_pkg::req_kind_t'(req_reg.req_type))
            oldq_pkg::REQ_PUSH: begin
                if (count_reg < CW'(D)) begin
                    entries_next[count_reg[IW-1:0]] = val;
                    count_next = count_reg + CW'(1);
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_POP: begin
                if (count_reg != '0) begin
                    rv = entries_reg[top_idx];
                    count_next = count_reg - CW'(1);
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_SHIFT: begin
                if (count_reg != '0) begin
                    rv = entries_reg[0];
                    del_en = 1'b1;
                    del_mask = '1;
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_GET: begin
                if (in_range) begin
                    rv = entries_reg[pos_idx];
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_DELETE: begin
                if (in_range) begin
                    del_en = 1'b1;
                    for (int i = 0; i < D; i++) del_mask[i] = (IW'(i) >= pos_idx);
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_REMOVE: begin
                if (val != '0 && match != '0) begin
                    del_en = 1'b1;
                    // thermometer from the first hit upwards
                    for (int i = 0; i < D; i++) del_mask[i] = |(first_hit & ((D'(1) << (i + 1)) - D'(1)));
                    ok = 1'b1;
                end
            end
            oldq_pkg::REQ_COUNT: ok = 1'b1;
            default: ;
        endcase
        if (del_en) begin
            for (int i = 0; i < D - 1; i++)
                if (del_mask[i]) entries_next[i] = entries_reg[i + 1];
            count_next = count_reg - CW'(1);
        end
        rsp_next.ok          = ok;
        rsp_next.read_value  = 32'(rv);
        rsp_next.entry_count = 5'(count_next);
    end

    // state and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) req_reg <= req_in;
        if (cmd.exec) begin
            rsp_reg <= rsp_next;
            for (int i = 0; i < D; i++) entries_reg[i] <= entries_next[i];
        end
    end

    assign rsp_out = rsp_reg;

    // count never exceeds depth
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(D)) else $error("count above depth");
    // exec changes count by at most one
    a_cnt_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1)
                      || count_reg == $past(count_reg) - CW'(1)))
        else $error("count jumped");
    // count only moves on exec
    a_cnt_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> $stable(count_reg)) else $error("count moved while idle");

endmodule

>>> src/oldq_ctrl.sv
`timescale 1ns / 1ps

module oldq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output oldq_pkg::dp_cmd_t cmd
);

    oldq_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= oldq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        case (state_reg)
            oldq_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = oldq_pkg::ST_EXEC;
                end
            end
            oldq_pkg::ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = oldq_pkg::ST_RESP;
            end
            oldq_pkg::ST_RESP: begin
                m_valid = 1'b1;
                s_ready = m_ready;
                if (m_ready) begin
                    if (s_valid) begin
                        cmd.load   = 1'b1;
                        state_next = oldq_pkg::ST_EXEC;
                    end else begin
                        state_next = oldq_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = oldq_pkg::ST_IDLE;
        endcase
    end

    a_no_exec_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid) else $error("no result after exec");
    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec) else $error("load not followed by exec");
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && (s_ready || m_valid))) else $error("exec overlaps handshake");

endmodule

>>> src/ordered_list_deque_engine.sv
`timescale 1ns / 1ps

// Ordered list engine: a deque of up to 16 32-bit values with push/pop at
// the tail, shift at the head, indexed get and delete, remove-by-value and
// count. Each request returns one beat with ok, a value and the new count.
// A request is captured, then executed in the shift cells, and the result
// register holds the beat until the sink takes it. A new request is taken
// only while no beat waits or as the waiting beat is taken. Stored values
// are flops, so no clearing pass is needed after reset.
module ordered_list_deque_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  oldq_pkg::req_beat_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output oldq_pkg::rsp_beat_t m_data
);

    oldq_pkg::dp_cmd_t cmd;

    oldq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    oldq_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .req_in  (s_data),
        .rsp_out (m_data)
    );

endmodule

>>> bench/tb_ordered_list_deque_engine.sv
`timescale 1ns / 1ps

module tb_ordered_list_deque_engine;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    oldq_pkg::req_beat_t s_data;
    logic                m_valid;
    logic                m_ready;
    oldq_pkg::rsp_beat_t m_data;

    int unsigned err_count = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_seen = 0;
    bit          hold_off = 0;

    ordered_list_deque_engine dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp);
        $display("MISMATCH %s: got %0h exp %0h (beat %0d)", what, got, exp, beats_seen);
        err_count++;
    endtask

    // Deque shadow and queue of expected response beats
    class deque_scoreboard;
        logic [31:0]         store[$];
        oldq_pkg::rsp_beat_t pending[$];

        function void note_request(oldq_pkg::req_beat_t r);
            oldq_pkg::rsp_beat_t e;
            int                  hit;
            e = '0;
            case (oldq_pkg::req_kind_t'(r.req_type))
                oldq_pkg::REQ_PUSH: if (store.size() < oldq_pkg::DEPTH) begin
                    store.push_back(r.item_value);
                    e.ok = 1'b1;
                end
                oldq_pkg::REQ_POP: if (store.size() > 0) begin
                    e.read_value = store.pop_back();
                    e.ok = 1'b1;
                end
                oldq_pkg::REQ_SHIFT: if (store.size() > 0) begin
                    e.read_value = store.pop_front();
                    e.ok = 1'b1;
                end
                oldq_pkg::REQ_GET: if (r.position < store.size()) begin
                    e.read_value = store[r.position];
                    e.ok = 1'b1;
                end
                oldq_pkg::REQ_DELETE: if (r.position < store.size()) begin
                    store.delete(r.position);
                    e.ok = 1'b1;
                end
                oldq_pkg::REQ_REMOVE: if (r.item_value != 0) begin
                    hit = -1;
                    foreach (store[i])
                        if (hit < 0 && store[i] == r.item_value) hit = i;
                    if (hit >= 0) begin
                        store.delete(hit);
                        e.ok = 1'b1;
                    end
                end
                oldq_pkg::REQ_COUNT: e.ok = 1'b1;
                default: ;
            endcase
            e.entry_count = 5'(store.size());
            pending.push_back(e);
        endfunction

        task check_response(oldq_pkg::rsp_beat_t got);
            oldq_pkg::rsp_beat_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat", 32'(got), 32'd0);
                return;
            end
            e = pending.pop_front();
            if (got.ok !== e.ok) report_mismatch("ok", 32'(got.ok), 32'(e.ok));
            if (got.read_value !== e.read_value)
                report_mismatch("read_value", got.read_value, e.read_value);
            if (got.entry_count !== e.entry_count)
                report_mismatch("entry_count", 32'(got.entry_count), 32'(e.entry_count));
        endtask
    endclass

    deque_scoreboard sb = new();

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send one request beat, with a random gap first if gaps is set; valid stays up when
    // the next beat follows straight on
    task automatic send_req(input oldq_pkg::req_kind_t k, input logic [7:0] pos,
                            input logic [31:0] val, input bit gaps);
        int g;
        oldq_pkg::req_beat_t r;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        r.req_type = k;
        r.position = pos;
        r.item_value = val;
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        beats_sent++;
    endtask

    task automatic drain_wait();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // A value likely to be present, for remove
    function automatic logic [31:0] pick_value();
        if (sb.store.size() > 0 && $urandom_range(0, 3) != 0)
            return sb.store[$urandom_range(0, sb.store.size() - 1)];
        return $urandom_range(0, 7) == 0 ? 32'd0 : $urandom;
    endfunction

    function automatic logic [7:0] pick_pos();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return 8'($urandom_range(0, 17));
        if (p < 9) return 8'($urandom);
        return 8'hFF;
    endfunction

    // Receiver: random stalls, and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sb.check_response(m_data);
                beats_seen++;
            end
            m_ready <= hold_off ? 1'b0 : ($urandom_range(0, 99) < 70);
        end
    end

    initial begin
        int cnt;
        cnt = 0;
        wait (beats_sent == 300);
        hold_off = 1;
        while (cnt < 200) begin
            @(posedge aclk);
            cnt++;
        end
        hold_off = 0;
    end

    initial begin
        oldq_pkg::req_kind_t k;
        int                  p;
        s_valid = 0;
        s_data  = '0;
        aresetn = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty cases, fill past full, stored zero, bad index
        send_req(oldq_pkg::REQ_POP, 0, 0, 0);
        send_req(oldq_pkg::REQ_SHIFT, 0, 0, 0);
        send_req(oldq_pkg::REQ_GET, 0, 0, 0);
        send_req(oldq_pkg::REQ_DELETE, 0, 0, 0);
        send_req(oldq_pkg::REQ_REMOVE, 0, 0, 0);
        send_req(oldq_pkg::REQ_COUNT, 8'hFF, 32'hFFFF_FFFF, 0);
        send_req(oldq_pkg::REQ_NONE, 8'hFF, 32'hFFFF_FFFF, 0);
        send_req(oldq_pkg::REQ_PUSH, 0, 32'd0, 0);
        send_req(oldq_pkg::REQ_PUSH, 0, 32'hFFFF_FFFF, 0);
        for (int i = 0; i < 15; i++) send_req(oldq_pkg::REQ_PUSH, 8'hFF, 32'h1000 + i, 0);
        send_req(oldq_pkg::REQ_GET, 8'd15, 0, 0);
        send_req(oldq_pkg::REQ_GET, 8'd16, 0, 0);
        send_req(oldq_pkg::REQ_GET, 8'hFF, 0, 0);
        send_req(oldq_pkg::REQ_REMOVE, 0, 32'h1005, 0);
        send_req(oldq_pkg::REQ_REMOVE, 0, 32'hDEAD, 0);
        send_req(oldq_pkg::REQ_DELETE, 8'd0, 0, 0);
        send_req(oldq_pkg::REQ_SHIFT, 0, 0, 0);
        send_req(oldq_pkg::REQ_POP, 0, 0, 0);
        drain_wait();

        // Random, in push- and pop-weighted phases so the store swings between empty and full
        for (int n = 0; n < 1400; n++) begin
            p = $urandom_range(0, 99);
            if (n % 400 < 120)
                k = (p < 60) ? oldq_pkg::REQ_PUSH : oldq_pkg::req_kind_t'($urandom_range(1, 7));
            else if (n % 400 < 200)
                k = (p < 60) ? oldq_pkg::REQ_POP : oldq_pkg::req_kind_t'($urandom_range(0, 7));
            else
                k = (p < 30) ? oldq_pkg::REQ_PUSH : oldq_pkg::req_kind_t'($urandom_range(0, 7));
            send_req(k, pick_pos(), k == oldq_pkg::REQ_REMOVE ? pick_value() :
                     ($urandom_range(0, 15) == 0 ? 32'd0 : $urandom), 1);
            if (n == 700) drain_wait();
        end

        drain_wait();
        repeat (10) @(posedge aclk);
        $display("Covered %0d requests of all kinds incl. full/empty, bad index, zero values.",
                 beats_sent);
        if (err_count == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
src/oldq_pkg.sv
src/oldq_datapath.sv
src/oldq_ctrl.sv
src/ordered_list_deque_engine.sv
bench/tb_ordered_list_deque_engine.sv
